// ===== src/iss_pkg.sv =====
// iss_pkg: constants and types for the interval schedule selector
// no dependencies; imported by interval_schedule_selector
`timescale 1ns / 1ps
`default_nettype none
package iss_pkg;

  // store capacity and stored time width
  localparam int MAX_ACTIVITIES = 64;
  localparam int TIME_BITS      = 16;

  // derived widths
  localparam int ADDR_W  = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
  localparam int CNT_W   = $clog2(MAX_ACTIVITIES + 1);

  // port field widths
  localparam int FIELD_W = 16;

  // one stored activity, finish in the upper half
  typedef struct packed {
    logic [TIME_BITS-1:0] finish;
    logic [TIME_BITS-1:0] start;
  } entry_t;

endpackage
`default_nettype wire

// ===== src/interval_schedule_selector.sv =====
// interval_schedule_selector: insertion-sorted activity store and greedy selection
// depends on iss_pkg; the store is a single-port-write memory inside this module
// insert: a read and a compare step per stored entry with a later finish, then a write;
// one input beat is taken per insert walk, as the walk goes entry by entry through
// the single read port of the activity memory
// results: after the last input beat, each output beat is read, built and held until taken
// reset: rst_n synchronous active low clears count, flags and handshakes; memory is not
// cleared, only entries below the count are ever read
`timescale 1ns / 1ps
`default_nettype none
module interval_schedule_selector
  import iss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] start_time, [31:16] finish_time
  input  wire logic        in_tlast,   // last_item
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] start_out, [31:16] finish_out
  output logic [1:0]       out_tuser,  // [0] chosen, [1] overflow
  output logic             out_tlast   // last_out
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_WR   = 7'b0001000,
    S_ERD  = 7'b0010000,
    S_EDAT = 7'b0100000,
    S_EOUT = 7'b1000000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0]    pos_r, pos_nxt;
  logic [ADDR_W-1:0]    k_r, k_nxt;
  entry_t               new_r, new_nxt;
  logic                 last_r, last_nxt;
  logic                 ovf_r, ovf_nxt;
  logic                 any_r, any_nxt;
  logic [TIME_BITS-1:0] lastfin_r, lastfin_nxt;

  logic                 ov_r, ov_nxt;
  logic [31:0]          od_r, od_nxt;
  logic [1:0]           ou_r, ou_nxt;
  logic                 ol_r, ol_nxt;

  // activity memory
  entry_t               mem [MAX_ACTIVITIES];
  entry_t               rd_data_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 wr_en;
  logic [ADDR_W-1:0]    wr_addr;
  entry_t               wr_data;

  logic                 in_acc;
  logic                 pick;
  logic                 at_end;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

  // greedy rule and end of run
  assign pick   = !any_r || (rd_data_r.start >= lastfin_r);
  assign at_end = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);

  // memory ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // next state and datapath
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    k_nxt       = k_r;
    new_nxt     = new_r;
    last_nxt    = last_r;
    ovf_nxt     = ovf_r;
    any_nxt     = any_r;
    lastfin_nxt = lastfin_r;
    ov_nxt      = ov_r;
    od_nxt      = od_r;
    ou_nxt      = ou_r;
    ol_nxt      = ol_r;
    wr_en       = 1'b0;
    wr_addr     = pos_r;
    wr_data     = new_r;
    rd_addr     = (state_r == S_ERD) ? k_r : (pos_r - ADDR_W'(1));

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          new_nxt.start  = TIME_BITS'(in_tdata[FIELD_W-1:0]);
          new_nxt.finish = TIME_BITS'(in_tdata[2*FIELD_W-1:FIELD_W]);
          last_nxt       = in_tlast;
          pos_nxt        = ADDR_W'(count_r);
          k_nxt          = '0;
          if (count_r >= CNT_W'(MAX_ACTIVITIES)) begin
            // store full, drop the activity
            ovf_nxt   = 1'b1;
            state_nxt = in_tlast ? S_ERD : S_IDLE;
          end else if (count_r == '0) begin
            state_nxt = S_WR;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (rd_data_r.finish > new_r.finish) begin
          // shift the later entry up one place
          wr_en   = 1'b1;
          wr_data = rd_data_r;
          pos_nxt = pos_r - ADDR_W'(1);
          state_nxt = (pos_r == ADDR_W'(1)) ? S_WR : S_RD;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = last_r ? S_ERD : S_IDLE;
        end
      end
      S_WR: begin
        wr_en     = 1'b1;
        count_nxt = count_r + CNT_W'(1);
        state_nxt = last_r ? S_ERD : S_IDLE;
      end
      S_ERD: begin
        state_nxt = S_EDAT;
      end
      S_EDAT: begin
        // build the result beat
        ov_nxt = 1'b1;
        od_nxt = {FIELD_W'(rd_data_r.finish), FIELD_W'(rd_data_r.start)};
        ou_nxt = {ovf_r, pick};
        ol_nxt = at_end;
        if (pick) begin
          any_nxt     = 1'b1;
          lastfin_nxt = rd_data_r.finish;
        end
        state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (out_tready) begin
          ov_nxt = 1'b0;
          if (at_end) begin
            count_nxt   = '0;
            any_nxt     = 1'b0;
            lastfin_nxt = '0;
            ovf_nxt     = 1'b0;
            state_nxt   = S_IDLE;
          end else begin
            k_nxt     = k_r + ADDR_W'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      ovf_r     <= 1'b0;
      any_r     <= 1'b0;
      lastfin_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
      any_r     <= any_nxt;
      lastfin_r <= lastfin_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    k_r    <= k_nxt;
    new_r  <= new_nxt;
    last_r <= last_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
    ol_r   <= ol_nxt;
  end

`ifndef SYNTHESIS
  // a result beat is only presented while waiting for the sink
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == S_EOUT))
    else $error("result beat outside the output state");

  // the stored count never passes capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ACTIVITIES))
    else $error("activity count beyond capacity");

  // the last result beat closes the run and frees the store
  a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (count_r == '0) && in_tready)
    else $error("run not closed after last result");

  // a run emits results only with a non-empty store
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERD) |-> (count_r != '0))
    else $error("emitting from an empty store");
`endif

endmodule
`default_nettype wire
